FILE: hdl/srt_pkg.sv
`timescale 1ns / 1ps

package srt_pkg;

  // default table depth
  localparam int MAX_PROCS_DEF = 16;

  // field widths
  localparam int CMD_W      = 2;
  localparam int SLOT_W     = 4;
  localparam int AT_W       = 8;
  localparam int BL_W       = 8;
  localparam int EV_W       = 3;
  localparam int TIME_W     = 16;
  localparam int TOTAL_W    = 20;
  localparam int CNT_W      = 5;
  localparam int LAT_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // running sums, wide enough for the largest table depth, with sign
  localparam int SUM_W = 24;
  localparam logic [SUM_W-1:0] TOTAL_MAX = SUM_W'(1048575);

  // request commands
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP    = 2'd2;

  // result events
  localparam logic [EV_W-1:0] EV_LOADED    = 3'd0;
  localparam logic [EV_W-1:0] EV_RESTARTED = 3'd1;
  localparam logic [EV_W-1:0] EV_DISPATCH  = 3'd2;
  localparam logic [EV_W-1:0] EV_IDLE_JUMP = 3'd3;
  localparam logic [EV_W-1:0] EV_DONE      = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_LATENCY = 1'd1;

  // operation broadcast to the cells
  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_RESTART,
    OP_DISPATCH
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [AT_W-1:0]     arrival;
    logic [BL_W-1:0]     burst;
    logic [TIME_W-1:0]   t_start;
    logic [TIME_W-1:0]   t_end;
  } upd_t;

  // search record walking down the chain
  typedef struct packed {
    logic              valid;
    logic              any_left;
    logic              found;
    logic [BL_W-1:0]   shortest;
    logic              have_next;
    logic [AT_W-1:0]   next_arr;
    logic [SUM_W-1:0]  wait_sum;
    logic [SUM_W-1:0]  resp_sum;
  } probe_t;

endpackage

FILE: hdl/srt_req_if.sv
`timescale 1ns / 1ps

interface srt_req_if import srt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SLOT_W-1:0] slot;
  logic [AT_W-1:0]   arrival_time;
  logic [BL_W-1:0]   burst_length;

  modport source (output valid, command, slot, arrival_time, burst_length, input ready);
  modport sink (input valid, command, slot, arrival_time, burst_length, output ready);
endinterface

FILE: hdl/srt_res_if.sv
`timescale 1ns / 1ps

interface srt_res_if import srt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [EV_W-1:0]    event_res;
  logic [TIME_W-1:0]  event_time;
  logic [SLOT_W-1:0]  chosen_slot;
  logic               switched;
  logic               finished_now;
  logic [TOTAL_W-1:0] total_wait_time;
  logic [TOTAL_W-1:0] total_response_time;

  modport source (output valid, event_res, event_time, chosen_slot, switched, finished_now,
                  total_wait_time, total_response_time, input ready);
  modport sink (input valid, event_res, event_time, chosen_slot, switched, finished_now,
                total_wait_time, total_response_time, output ready);
endinterface

FILE: hdl/shortest_remaining_time_scheduler.sv
`timescale 1ns / 1ps

// Preemptive shortest-remaining-time scheduler over MAX_PROCS process slots.
// Requests arrive on req_i (valid/ready): load writes one slot, restart zeroes
// the clock and refills all slots, step advances the schedule by one decision.
// Every request except command 3 gives exactly one result on res_o.
// Configuration (process_count, switch_latency) is written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write it only while the block is
// idle, which the block itself does not enforce.
// Load and restart: the result is valid the cycle after the request is taken.
// Step: a search record walks the row of slot cells one cell per cycle; one
// step is in flight at a time, and no request is taken until it completes.
// The result sits in an output register; req_i.ready is low while a step is
// in flight, and while a result is held against a stalled receiver.
// Reset clears the clock, the running slot, all started marks and restores
// process_count to 2 and switch_latency to 0; slot tables keep whatever they
// hold until loaded.
module shortest_remaining_time_scheduler import srt_pkg::*; #(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  srt_req_if.sink               req_i,
  srt_res_if.source             res_o
);

  localparam int IDX_W = $clog2(MAX_PROCS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                state_q, state_d;
  logic [CNT_W-1:0]    cnt_q;
  logic [LAT_W-1:0]    lat_q;
  logic [TIME_W-1:0]   time_q, time_d;
  logic                run_valid_q, run_valid_d;
  logic [IDX_W-1:0]    run_slot_q, run_slot_d;

  logic                out_valid_q, out_valid_d, out_set;
  logic [EV_W-1:0]     ev_q, ev_d;
  logic [TIME_W-1:0]   evt_q, evt_d;
  logic [SLOT_W-1:0]   chosen_q, chosen_d;
  logic                sw_q, sw_d;
  logic                fin_q, fin_d;
  logic [TOTAL_W-1:0]  wait_q, wait_d;
  logic [TOTAL_W-1:0]  resp_q, resp_d;

  probe_t              chain [MAX_PROCS+1];
  logic [IDX_W-1:0]    best_chain [MAX_PROCS+1];
  logic [MAX_PROCS-1:0] active, sel, pv;
  upd_t                upd;
  logic                req_fire;
  probe_t              fin;
  logic [IDX_W-1:0]    best;
  logic                sw;
  logic [TIME_W:0]     sum_lat, sum_one;
  logic [TIME_W-1:0]   t_start, t_end;

  assign req_i.ready = (state_q == ST_IDLE) && (!out_valid_q || res_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;
  assign fin         = chain[MAX_PROCS];
  assign best        = best_chain[MAX_PROCS];

  // injected search record, launched by an accepted step request
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = req_fire && (req_i.command == CMD_STEP);
    best_chain[0]  = '0;
  end

  // row of slot cells
  for (genvar k = 0; k < MAX_PROCS; k++) begin : g_cell
    assign active[k] = (int'(cnt_q) > k);
    assign pv[k]     = chain[k+1].valid;
    srt_cell #(
      .IDX_W (IDX_W),
      .IDX   (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .active_i(active[k]),
      .sel_i   (sel[k]),
      .upd_i   (upd),
      .time_i  (time_q),
      .probe_i (chain[k]),
      .best_i  (best_chain[k]),
      .probe_o (chain[k+1]),
      .best_o  (best_chain[k+1])
    );
  end

  // dispatch timing with saturation
  always_comb begin
    sw      = run_valid_q && (run_slot_q != best);
    sum_lat = {1'b0, time_q} + (TIME_W+1)'(lat_q);
    if (!sw) begin
      t_start = time_q;
    end else if (sum_lat[TIME_W]) begin
      t_start = '1;
    end else begin
      t_start = sum_lat[TIME_W-1:0];
    end
    sum_one = {1'b0, t_start} + (TIME_W+1)'(1);
    t_end   = sum_one[TIME_W] ? '1 : sum_one[TIME_W-1:0];
  end

  // request decode and step completion
  always_comb begin
    state_d     = state_q;
    time_d      = time_q;
    run_valid_d = run_valid_q;
    run_slot_d  = run_slot_q;
    upd         = '0;
    upd.op      = OP_NONE;
    sel         = '0;
    out_set     = 1'b0;
    ev_d        = ev_q;
    evt_d       = '0;
    chosen_d    = '0;
    sw_d        = 1'b0;
    fin_d       = 1'b0;
    wait_d      = '0;
    resp_d      = '0;

    if (req_fire) begin
      case (req_i.command)
        CMD_LOAD: begin
          upd.op      = OP_LOAD;
          upd.arrival = req_i.arrival_time;
          upd.burst   = req_i.burst_length;
          for (int k = 0; k < MAX_PROCS; k++) begin
            sel[k] = (int'(req_i.slot) == k);
          end
          out_set = 1'b1;
          ev_d    = EV_LOADED;
        end
        CMD_RESTART: begin
          upd.op      = OP_RESTART;
          time_d      = '0;
          run_valid_d = 1'b0;
          run_slot_d  = '0;
          out_set     = 1'b1;
          ev_d        = EV_RESTARTED;
        end
        CMD_STEP: begin
          state_d = ST_SCAN;
        end
        default: begin
        end
      endcase
    end

    if ((state_q == ST_SCAN) && fin.valid) begin
      state_d = ST_IDLE;
      out_set = 1'b1;
      if (!fin.any_left) begin
        ev_d  = EV_DONE;
        evt_d = time_q;
        if (fin.wait_sum[SUM_W-1]) begin
          wait_d = '0;
        end else if (fin.wait_sum > TOTAL_MAX) begin
          wait_d = '1;
        end else begin
          wait_d = fin.wait_sum[TOTAL_W-1:0];
        end
        if (fin.resp_sum[SUM_W-1]) begin
          resp_d = '0;
        end else if (fin.resp_sum > TOTAL_MAX) begin
          resp_d = '1;
        end else begin
          resp_d = fin.resp_sum[TOTAL_W-1:0];
        end
      end else if (!fin.found) begin
        ev_d = EV_IDLE_JUMP;
        if (fin.have_next) begin
          time_d = TIME_W'(fin.next_arr);
          evt_d  = TIME_W'(fin.next_arr);
        end else begin
          evt_d = time_q;
        end
      end else begin
        upd.op      = OP_DISPATCH;
        upd.t_start = t_start;
        upd.t_end   = t_end;
        for (int k = 0; k < MAX_PROCS; k++) begin
          sel[k] = (int'(best) == k);
        end
        ev_d        = EV_DISPATCH;
        evt_d       = t_start;
        chosen_d    = SLOT_W'(best);
        sw_d        = sw;
        fin_d       = (fin.shortest == BL_W'(1));
        time_d      = t_end;
        run_valid_d = 1'b1;
        run_slot_d  = best;
      end
    end

    if (out_set) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      time_q      <= '0;
      run_valid_q <= 1'b0;
      run_slot_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      time_q      <= time_d;
      run_valid_q <= run_valid_d;
      run_slot_q  <= run_slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_W'(2);
      lat_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PROCESS_COUNT:  cnt_q <= cfg_data_i[CNT_W-1:0];
        CFG_SWITCH_LATENCY: lat_q <= cfg_data_i[LAT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_set) begin
      ev_q     <= ev_d;
      evt_q    <= evt_d;
      chosen_q <= chosen_d;
      sw_q     <= sw_d;
      fin_q    <= fin_d;
      wait_q   <= wait_d;
      resp_q   <= resp_d;
    end
  end

  assign res_o.valid               = out_valid_q;
  assign res_o.event_res           = ev_q;
  assign res_o.event_time          = evt_q;
  assign res_o.chosen_slot         = chosen_q;
  assign res_o.switched            = sw_q;
  assign res_o.finished_now        = fin_q;
  assign res_o.total_wait_time     = wait_q;
  assign res_o.total_response_time = resp_q;

  // only one search record in the row at a time
  a_one_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(pv))
    else $error("more than one search record in flight");

  // a record leaves the row only during a step
  a_probe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin.valid |-> (state_q == ST_SCAN))
    else $error("search record outside of a step");

  // a fresh dispatch result leaves the clock one unit past its start
  a_dispatch_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && (ev_q == EV_DISPATCH)) |->
      ((time_q == evt_q + TIME_W'(1)) || (evt_q == '1)))
    else $error("clock does not follow dispatch");

endmodule

FILE: hdl/srt_cell.sv
`timescale 1ns / 1ps

module srt_cell import srt_pkg::*; #(
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              active_i,
  input  logic              sel_i,
  input  upd_t              upd_i,
  input  logic [TIME_W-1:0] time_i,
  input  probe_t            probe_i,
  input  logic [IDX_W-1:0]  best_i,
  output probe_t            probe_o,
  output logic [IDX_W-1:0]  best_o
);

  logic [AT_W-1:0]   arr_q, arr_d;
  logic [BL_W-1:0]   burst_q, burst_d;
  logic [BL_W-1:0]   rem_q, rem_d;
  logic [TIME_W-1:0] fs_q, fs_d;
  logic [TIME_W-1:0] comp_q, comp_d;
  logic              started_q, started_d;
  probe_t            probe_q, probe_d;
  logic [IDX_W-1:0]  best_q, best_d;

  logic              eligible, arrived, take_best, take_next;
  logic [SUM_W-1:0]  wait_term, resp_term;

  // compare this slot against the record handed in by the left neighbor
  always_comb begin
    eligible  = active_i && (rem_q != '0);
    arrived   = (TIME_W'(arr_q) <= time_i);
    take_best = eligible && arrived && (!probe_i.found || (rem_q < probe_i.shortest));
    take_next = eligible && !arrived && (!probe_i.have_next || (arr_q < probe_i.next_arr));
    wait_term = SUM_W'(comp_q) - SUM_W'(arr_q) - SUM_W'(burst_q);
    resp_term = SUM_W'(fs_q) - SUM_W'(arr_q);

    probe_d = probe_i;
    best_d  = best_i;
    if (eligible) begin
      probe_d.any_left = 1'b1;
    end
    if (take_best) begin
      probe_d.found    = 1'b1;
      probe_d.shortest = rem_q;
      best_d           = IDX_W'(IDX);
    end
    if (take_next) begin
      probe_d.have_next = 1'b1;
      probe_d.next_arr  = arr_q;
    end
    if (active_i) begin
      probe_d.wait_sum = probe_i.wait_sum + wait_term;
      probe_d.resp_sum = probe_i.resp_sum + resp_term;
    end
  end

  // slot state updates
  always_comb begin
    arr_d     = arr_q;
    burst_d   = burst_q;
    rem_d     = rem_q;
    fs_d      = fs_q;
    comp_d    = comp_q;
    started_d = started_q;
    case (upd_i.op)
      OP_LOAD: begin
        if (sel_i) begin
          arr_d     = upd_i.arrival;
          burst_d   = upd_i.burst;
          rem_d     = upd_i.burst;
          started_d = 1'b0;
        end
      end
      OP_RESTART: begin
        rem_d     = burst_q;
        started_d = 1'b0;
      end
      OP_DISPATCH: begin
        if (sel_i) begin
          if (!started_q) begin
            fs_d      = upd_i.t_start;
            started_d = 1'b1;
          end
          rem_d = rem_q - BL_W'(1);
          if (rem_q == BL_W'(1)) begin
            comp_d = upd_i.t_end;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // slot tables, never cleared
  always_ff @(posedge clk_i) begin
    arr_q   <= arr_d;
    burst_q <= burst_d;
    rem_q   <= rem_d;
    fs_q    <= fs_d;
    comp_q  <= comp_d;
    best_q  <= best_d;
  end

  // started mark and search record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      probe_q   <= '0;
    end else begin
      started_q <= started_d;
      probe_q   <= probe_d;
    end
  end

  assign probe_o = probe_q;
  assign best_o  = best_q;

endmodule

FILE: verif/tb_shortest_remaining_time_scheduler.sv
`timescale 1ns / 1ps

module tb_shortest_remaining_time_scheduler;
  import srt_pkg::*;

  // command code the block drops without a result
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 2 * MAX_PROCS_DEF + 8;

  typedef struct packed {
    logic [EV_W-1:0]    ev;
    logic [TIME_W-1:0]  stamp;
    logic [SLOT_W-1:0]  slot;
    logic               sw;
    logic               fin;
    logic [TOTAL_W-1:0] wait_sum;
    logic [TOTAL_W-1:0] resp_sum;
  } sched_res_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  srt_req_if req_bus ();
  srt_res_if res_bus ();

  shortest_remaining_time_scheduler u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_bus),
    .res_o      (res_bus)
  );

  // scheduler image kept by the testbench
  logic [AT_W-1:0]   arr_tab   [MAX_PROCS_DEF];
  logic [BL_W-1:0]   burst_tab [MAX_PROCS_DEF];
  logic [BL_W-1:0]   left_tab  [MAX_PROCS_DEF];
  logic [TIME_W-1:0] first_tab [MAX_PROCS_DEF];
  logic [TIME_W-1:0] done_tab  [MAX_PROCS_DEF];
  logic              started   [MAX_PROCS_DEF];
  logic [TIME_W-1:0] sched_clock;
  logic              run_valid;
  logic [SLOT_W-1:0] run_slot;
  logic [CNT_W-1:0]  proc_count;
  logic [LAT_W-1:0]  latency;

  sched_res_t  pending_events [$];
  sched_res_t  want;
  int unsigned err_cnt;
  int unsigned sent_items;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned hold_off;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned exp_v);
    err_cnt++;
    if (err_cnt <= 50) begin
      $display("mismatch %s: got %0d, want %0d at %0t ns", what, got, exp_v, $time);
    end
  endtask

  function automatic logic [TIME_W-1:0] clamp_time(input int unsigned v);
    return (v > 65535) ? '1 : TIME_W'(v);
  endfunction

  function automatic logic [TOTAL_W-1:0] clamp_total(input longint v);
    if (v < 0) return '0;
    if (v > longint'(TOTAL_MAX)) return '1;
    return TOTAL_W'(v);
  endfunction

  function automatic int unsigned active_slots();
    return (proc_count > MAX_PROCS_DEF) ? MAX_PROCS_DEF : proc_count;
  endfunction

  function automatic logic work_pending();
    int i;
    for (i = 0; i < active_slots(); i++) begin
      if (left_tab[i] != 0) return 1'b1;
    end
    return 1'b0;
  endfunction

  // apply one accepted request to the image and queue the event it gives
  function automatic void advance_schedule(input logic [CMD_W-1:0] cmd,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic [AT_W-1:0] arr,
                                           input logic [BL_W-1:0] burst);
    sched_res_t        r;
    int                i;
    int unsigned       n;
    logic              any_left, found, have_next, sw;
    logic [SLOT_W-1:0] best;
    logic [BL_W-1:0]   shortest;
    logic [AT_W-1:0]   next_arr;
    longint            wait_acc, resp_acc;
    if (cmd == CMD_UNUSED) return;
    r = '0;
    n = active_slots();
    case (cmd)
      CMD_LOAD: begin
        arr_tab[slot]   = arr;
        burst_tab[slot] = burst;
        left_tab[slot]  = burst;
        started[slot]   = 1'b0;
        r.ev = EV_LOADED;
      end
      CMD_RESTART: begin
        for (i = 0; i < MAX_PROCS_DEF; i++) begin
          left_tab[i] = burst_tab[i];
          started[i]  = 1'b0;
        end
        sched_clock = '0;
        run_valid   = 1'b0;
        run_slot    = '0;
        r.ev = EV_RESTARTED;
      end
      CMD_STEP: begin
        any_left = 1'b0;
        found    = 1'b0;
        best     = '0;
        shortest = '0;
        // shortest remaining among arrived slots, lowest index on ties
        for (i = 0; i < n; i++) begin
          if (left_tab[i] != 0) begin
            any_left = 1'b1;
            if (arr_tab[i] <= sched_clock && (!found || left_tab[i] < shortest)) begin
              found    = 1'b1;
              best     = SLOT_W'(i);
              shortest = left_tab[i];
            end
          end
        end
        if (!any_left) begin
          wait_acc = 0;
          resp_acc = 0;
          for (i = 0; i < n; i++) begin
            wait_acc += longint'(done_tab[i]) - longint'(arr_tab[i]) - longint'(burst_tab[i]);
            resp_acc += longint'(first_tab[i]) - longint'(arr_tab[i]);
          end
          r.ev       = EV_DONE;
          r.stamp    = sched_clock;
          r.wait_sum = clamp_total(wait_acc);
          r.resp_sum = clamp_total(resp_acc);
        end else if (!found) begin
          // nothing arrived yet: jump to the earliest pending arrival
          have_next = 1'b0;
          next_arr  = '0;
          for (i = 0; i < n; i++) begin
            if (left_tab[i] != 0 && arr_tab[i] > sched_clock &&
                (!have_next || arr_tab[i] < next_arr)) begin
              have_next = 1'b1;
              next_arr  = arr_tab[i];
            end
          end
          if (have_next) sched_clock = TIME_W'(next_arr);
          r.ev    = EV_IDLE_JUMP;
          r.stamp = sched_clock;
        end else begin
          sw = run_valid && (run_slot != best);
          if (sw) sched_clock = clamp_time(int'(sched_clock) + int'(latency));
          if (!started[best]) begin
            first_tab[best] = sched_clock;
            started[best]   = 1'b1;
          end
          r.ev    = EV_DISPATCH;
          r.stamp = sched_clock;
          r.slot  = best;
          r.sw    = sw;
          left_tab[best] = left_tab[best] - 1'b1;
          sched_clock = clamp_time(int'(sched_clock) + 1);
          if (left_tab[best] == 0) begin
            done_tab[best] = sched_clock;
            r.fin = 1'b1;
          end
          run_valid = 1'b1;
          run_slot  = best;
        end
      end
      default: begin
      end
    endcase
    pending_events.push_back(r);
  endfunction

  // offer one request and wait until the block takes it
  task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                          input logic [AT_W-1:0] arr, input logic [BL_W-1:0] burst);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.command      <= cmd;
    req_bus.slot         <= slot;
    req_bus.arrival_time <= arr;
    req_bus.burst_length <= burst;
    do @(posedge clk_i); while (!req_bus.ready);
    advance_schedule(cmd, slot, arr, burst);
    if (cmd != CMD_UNUSED) sent_items++;
  endtask

  task automatic send_step();
    send_req(CMD_STEP, SLOT_W'($urandom), AT_W'($urandom), BL_W'($urandom));
  endtask

  task automatic req_quiet();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
  endtask

  // wait until every event is back and the block has settled
  task automatic drain();
    req_quiet();
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_PROCESS_COUNT) proc_count = data[CNT_W-1:0];
    else latency = data[LAT_W-1:0];
  endtask

  function automatic logic [AT_W-1:0] pick_arrival();
    return ($urandom_range(99) < 70) ? AT_W'($urandom_range(0, 12)) : AT_W'($urandom);
  endfunction

  function automatic logic [BL_W-1:0] pick_burst();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 6) return '0;
    if (p < 12) return BL_W'($urandom);
    return BL_W'($urandom_range(1, 6));
  endfunction

  // extremes, ties, idle jump, switches, repeated done, load after completion
  task automatic test_directed();
    int s;
    write_reg(CFG_PROCESS_COUNT, 8'd16);
    write_reg(CFG_SWITCH_LATENCY, 8'd3);
    send_req(CMD_UNUSED, 4'hA, 8'h55, 8'hAA);
    send_req(CMD_LOAD, 4'd0, 8'hFF, 8'hFF);
    send_req(CMD_LOAD, 4'd0, 8'd2, 8'd2);
    for (s = 1; s < MAX_PROCS_DEF; s++) begin
      send_req(CMD_LOAD, SLOT_W'(s), (s == 15) ? 8'd5 : 8'd2, 8'd1);
    end
    while (work_pending()) send_step();
    send_step();
    send_step();
    send_req(CMD_LOAD, 4'd3, 8'd0, 8'd2);
    send_step();
    send_req(CMD_RESTART, 4'hF, 8'hFF, 8'hFF);
    drain();
  endtask

  // random schedules: configure, load, then step with some noise in between
  task automatic test_random_schedules(input int unsigned quota);
    int unsigned      start_cnt, steps, p, i;
    logic [CNT_W-1:0] cnt;
    logic [LAT_W-1:0] lat;
    start_cnt = sent_items;
    while (sent_items - start_cnt < quota) begin
      drain();
      p = $urandom_range(99);
      if (p < 65) cnt = CNT_W'($urandom_range(2, 6));
      else if (p < 85) cnt = CNT_W'($urandom_range(7, 16));
      else if (p < 90) cnt = CNT_W'(16);
      else cnt = CNT_W'($urandom_range(0, 31));
      p = $urandom_range(99);
      if (p < 25) lat = '0;
      else if (p < 35) lat = '1;
      else if (p < 70) lat = LAT_W'($urandom_range(1, 9));
      else lat = LAT_W'($urandom);
      write_reg(CFG_PROCESS_COUNT, CFG_DATA_W'(cnt));
      write_reg(CFG_SWITCH_LATENCY, lat);
      if ($urandom_range(99) < 80) begin
        send_req(CMD_RESTART, SLOT_W'($urandom), AT_W'($urandom), BL_W'($urandom));
      end
      for (i = 0; i < active_slots(); i++) begin
        if ($urandom_range(99) < 90) send_req(CMD_LOAD, SLOT_W'(i), pick_arrival(), pick_burst());
      end
      steps = 0;
      while (work_pending() && steps < 80) begin
        p = $urandom_range(99);
        if (p < 6) begin
          send_req(CMD_LOAD, SLOT_W'($urandom), pick_arrival(), pick_burst());
        end else if (p < 8) begin
          send_req(CMD_RESTART, SLOT_W'($urandom), AT_W'($urandom), BL_W'($urandom));
        end else if (p < 10) begin
          send_req(CMD_UNUSED, SLOT_W'($urandom), AT_W'($urandom), BL_W'($urandom));
        end else begin
          send_step();
          steps++;
        end
      end
      send_step();
    end
    drain();
  endtask

  // drive the clock into saturation with a switch on every dispatch after the first, then finish a full table
  task automatic test_clock_saturation();
    int unsigned k;
    drain();
    write_reg(CFG_PROCESS_COUNT, 8'd2);
    write_reg(CFG_SWITCH_LATENCY, 8'd255);
    send_req(CMD_RESTART, 4'd0, 8'd0, 8'd0);
    send_req(CMD_LOAD, 4'd0, 8'd0, 8'd1);
    send_req(CMD_LOAD, 4'd1, 8'd0, 8'd1);
    for (k = 0; k < 270; k++) begin
      send_req(CMD_LOAD, SLOT_W'(k % 2), (k < 4) ? 8'd0 : AT_W'($urandom), 8'd1);
      send_step();
    end
    drain();
    write_reg(CFG_PROCESS_COUNT, 8'd16);
    for (k = 0; k < MAX_PROCS_DEF; k++) begin
      send_req(CMD_LOAD, SLOT_W'(k), AT_W'($urandom), BL_W'($urandom_range(1, 3)));
    end
    while (work_pending()) send_step();
    send_step();
    drain();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    int unsigned k;
    drain();
    write_reg(CFG_PROCESS_COUNT, 8'd5);
    write_reg(CFG_SWITCH_LATENCY, 8'd9);
    hold_off = 400;
    send_req(CMD_RESTART, 4'd0, 8'd0, 8'd0);
    for (k = 0; k < 5; k++) begin
      send_req(CMD_LOAD, SLOT_W'(k), AT_W'($urandom_range(0, 10)), BL_W'($urandom_range(1, 8)));
    end
    while (work_pending()) send_step();
    send_step();
    drain();
  endtask

  // receiver side
  initial begin
    res_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        res_bus.ready <= 1'b0;
        hold_off--;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // compare every result with the oldest expected event
  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_events.size() == 0) begin
        flag_mismatch("result with nothing expected, event_res", res_bus.event_res, 0);
      end else begin
        want = pending_events.pop_front();
        if (res_bus.event_res !== want.ev)
          flag_mismatch("event_res", res_bus.event_res, want.ev);
        if (res_bus.event_time !== want.stamp)
          flag_mismatch("event_time", res_bus.event_time, want.stamp);
        if (res_bus.chosen_slot !== want.slot)
          flag_mismatch("chosen_slot", res_bus.chosen_slot, want.slot);
        if (res_bus.switched !== want.sw)
          flag_mismatch("switched", res_bus.switched, want.sw);
        if (res_bus.finished_now !== want.fin)
          flag_mismatch("finished_now", res_bus.finished_now, want.fin);
        if (res_bus.total_wait_time !== want.wait_sum)
          flag_mismatch("total_wait_time", res_bus.total_wait_time, want.wait_sum);
        if (res_bus.total_response_time !== want.resp_sum)
          flag_mismatch("total_response_time", res_bus.total_response_time, want.resp_sum);
      end
    end
  end

  // test sequence
  initial begin
    int i;
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_data             = '0;
    req_bus.valid        = 1'b0;
    req_bus.command      = CMD_LOAD;
    req_bus.slot         = '0;
    req_bus.arrival_time = '0;
    req_bus.burst_length = '0;
    err_cnt      = 0;
    sent_items   = 0;
    hold_off     = 0;
    src_idle_pct = 23;
    snk_idle_pct = 56;
    for (i = 0; i < MAX_PROCS_DEF; i++) begin
      arr_tab[i]   = '0;
      burst_tab[i] = '0;
      left_tab[i]  = '0;
      first_tab[i] = '0;
      done_tab[i]  = '0;
      started[i]   = 1'b0;
    end
    sched_clock = '0;
    run_valid   = 1'b0;
    run_slot    = '0;
    proc_count  = CNT_W'(2);
    latency     = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_schedules(350);

    src_idle_pct = 56;
    snk_idle_pct = 23;
    test_clock_saturation();
    test_random_schedules(300);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_backpressure();
    test_random_schedules(300);

    req_quiet();
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/srt_pkg.sv
hdl/srt_req_if.sv
hdl/srt_res_if.sv
hdl/srt_cell.sv
hdl/shortest_remaining_time_scheduler.sv
verif/tb_shortest_remaining_time_scheduler.sv
